// ===== hdl/bwa_pkg.sv =====
package bwa_pkg;

  localparam int unsigned CoordW    = 12;
  localparam int unsigned DiffW     = 13;
  localparam int unsigned DotW      = 28;
  localparam int unsigned BigW      = 56;
  localparam int unsigned NumW      = 57;
  localparam int unsigned ThrW      = 54;
  localparam int unsigned IndexW    = 12;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned WeightW   = 24;
  localparam int unsigned QuotW     = 24;
  localparam int unsigned SatShift  = 7;
  localparam int unsigned StatIdW   = 4;
  localparam int unsigned StatW     = 64;
  localparam int unsigned NumSums   = 10;
  localparam int unsigned MulSteps  = 16;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned CfgAddrW  = 6;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [2:0] RegV0X = 3'd0;
  localparam logic [2:0] RegV0Y = 3'd1;
  localparam logic [2:0] RegV1X = 3'd2;
  localparam logic [2:0] RegV1Y = 3'd3;
  localparam logic [2:0] RegV2X = 3'd4;
  localparam logic [2:0] RegV2Y = 3'd5;
  localparam logic [2:0] RegThr = 3'd6;

  localparam logic KindWeight = 1'b0;
  localparam logic KindStat   = 1'b1;

  localparam logic [StatIdW-1:0] StatCount = 4'd10;

  typedef struct packed {
    logic [CoordW-1:0] v0x;
    logic [CoordW-1:0] v0y;
    logic [CoordW-1:0] v1x;
    logic [CoordW-1:0] v1y;
    logic [CoordW-1:0] v2x;
    logic [CoordW-1:0] v2y;
    logic [ThrW-1:0]   thr;
  } cfg_t;

  // one point handed from the front to the back
  typedef struct packed {
    logic [IndexW-1:0]         index;
    logic signed [WeightW-1:0] w0;
    logic signed [WeightW-1:0] w1;
    logic signed [WeightW-1:0] w2;
    logic                      degen;
    logic signed [ValueW-1:0]  y;
    logic                      incl;
    logic                      last;
  } rec_t;

  typedef enum logic [3:0] {
    OPD_AX, OPD_AY, OPD_BX, OPD_BY, OPD_PX, OPD_PY,
    OPD_D00, OPD_D01, OPD_D11, OPD_D20, OPD_D21
  } opd_e;

  typedef enum logic [2:0] {
    DST_D00, DST_D01, DST_D11, DST_D20, DST_D21, DST_DEN, DST_NU, DST_NV
  } dst_e;

  typedef struct packed {
    opd_e a;
    opd_e b;
    dst_e dst;
    logic first;
    logic neg;
  } mstep_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_NW, F_ABS, F_SAT, F_DIV, F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE, B_ACC, B_STAT
  } back_state_e;

  // dot products, Gram determinant and the two numerators
  function automatic mstep_t mul_step(input logic [3:0] k);
    mstep_t s;
    s = '{a: OPD_AX, b: OPD_AX, dst: DST_D00, first: 1'b1, neg: 1'b0};
    case (k)
      4'd0:  s = '{a: OPD_AX,  b: OPD_AX,  dst: DST_D00, first: 1'b1, neg: 1'b0};
      4'd1:  s = '{a: OPD_AY,  b: OPD_AY,  dst: DST_D00, first: 1'b0, neg: 1'b0};
      4'd2:  s = '{a: OPD_AX,  b: OPD_BX,  dst: DST_D01, first: 1'b1, neg: 1'b0};
      4'd3:  s = '{a: OPD_AY,  b: OPD_BY,  dst: DST_D01, first: 1'b0, neg: 1'b0};
      4'd4:  s = '{a: OPD_BX,  b: OPD_BX,  dst: DST_D11, first: 1'b1, neg: 1'b0};
      4'd5:  s = '{a: OPD_BY,  b: OPD_BY,  dst: DST_D11, first: 1'b0, neg: 1'b0};
      4'd6:  s = '{a: OPD_PX,  b: OPD_AX,  dst: DST_D20, first: 1'b1, neg: 1'b0};
      4'd7:  s = '{a: OPD_PY,  b: OPD_AY,  dst: DST_D20, first: 1'b0, neg: 1'b0};
      4'd8:  s = '{a: OPD_PX,  b: OPD_BX,  dst: DST_D21, first: 1'b1, neg: 1'b0};
      4'd9:  s = '{a: OPD_PY,  b: OPD_BY,  dst: DST_D21, first: 1'b0, neg: 1'b0};
      4'd10: s = '{a: OPD_D00, b: OPD_D11, dst: DST_DEN, first: 1'b1, neg: 1'b0};
      4'd11: s = '{a: OPD_D01, b: OPD_D01, dst: DST_DEN, first: 1'b0, neg: 1'b1};
      4'd12: s = '{a: OPD_D11, b: OPD_D20, dst: DST_NU,  first: 1'b1, neg: 1'b0};
      4'd13: s = '{a: OPD_D01, b: OPD_D21, dst: DST_NU,  first: 1'b0, neg: 1'b1};
      4'd14: s = '{a: OPD_D00, b: OPD_D21, dst: DST_NV,  first: 1'b1, neg: 1'b0};
      default: s = '{a: OPD_D01, b: OPD_D20, dst: DST_NV, first: 1'b0, neg: 1'b1};
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/bwa_front.sv =====
module bwa_front
  import bwa_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IndexW-1:0]        point_index_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [ValueW-1:0] sample_value_i,
  input  logic                     included_i,
  input  logic                     last_point_i,
  output logic                     push_o,
  output rec_t                     rec_o,
  input  logic                     full_i
);

  front_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  logic [IndexW-1:0]        index_q;
  logic signed [ValueW-1:0] y_q;
  logic                     incl_q, last_q, degen_q;
  logic signed [DiffW-1:0]  ax_q, ay_q, bx_q, by_q, px_q, py_q;
  logic signed [DotW-1:0]   d00_q, d01_q, d11_q, d20_q, d21_q;
  logic signed [BigW-1:0]   den_q, nu_q, nv_q, prod_q;
  logic signed [NumW-1:0]   nw_q;
  logic [BigW-1:0]          mag_q [3];
  logic [BigW-1:0]          rem_q [3];
  logic [QuotW-1:0]         quo_q [3];
  logic [2:0]               neg_q, sat_q;

  logic signed [DotW-1:0]   opa, opb;
  logic signed [BigW-1:0]   prod_d, addend;
  mstep_t                   ms_mul, ms_acc;
  logic signed [NumW-1:0]   num [3];
  logic [2:0]               dsel;
  logic                     dbit;
  logic [NumW-1:0]          trial [3];
  logic [QuotW:0]           rnd [3];
  logic signed [WeightW-1:0] wgt [3];

  logic accept;

  assign accept     = (state_q == F_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != F_IDLE);

  assign ms_mul = mul_step(cnt_q[3:0]);
  assign ms_acc = mul_step(4'(cnt_q - 5'd1));

  always_comb begin
    unique case (ms_mul.a)
      OPD_AX:  opa = DotW'(ax_q);
      OPD_AY:  opa = DotW'(ay_q);
      OPD_BX:  opa = DotW'(bx_q);
      OPD_BY:  opa = DotW'(by_q);
      OPD_PX:  opa = DotW'(px_q);
      OPD_PY:  opa = DotW'(py_q);
      OPD_D00: opa = d00_q;
      OPD_D01: opa = d01_q;
      OPD_D11: opa = d11_q;
      OPD_D20: opa = d20_q;
      OPD_D21: opa = d21_q;
      default: opa = '0;
    endcase
    unique case (ms_mul.b)
      OPD_AX:  opb = DotW'(ax_q);
      OPD_AY:  opb = DotW'(ay_q);
      OPD_BX:  opb = DotW'(bx_q);
      OPD_BY:  opb = DotW'(by_q);
      OPD_PX:  opb = DotW'(px_q);
      OPD_PY:  opb = DotW'(py_q);
      OPD_D00: opb = d00_q;
      OPD_D01: opb = d01_q;
      OPD_D11: opb = d11_q;
      OPD_D20: opb = d20_q;
      OPD_D21: opb = d21_q;
      default: opb = '0;
    endcase
  end

  assign prod_d = opa * opb;
  assign addend = ms_acc.neg ? -prod_q : prod_q;

  assign num[0] = nw_q;
  assign num[1] = NumW'(nu_q);
  assign num[2] = NumW'(nv_q);

  // dividend is mag * 2^17, so its bits 16..0 are zero
  assign dsel = 3'(cnt_q - 5'd17);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l] = {rem_q[l], (cnt_q >= 5'd17) ? mag_q[l][dsel] : 1'b0};
      rnd[l]   = (QuotW + 1)'((QuotW + 1)'(quo_q[l]) + 1'b1) >> 1;
      if (sat_q[l]) begin
        rnd[l] = (QuotW + 1)'(1) << (WeightW - 1);
      end
      if (degen_q || !incl_q) begin
        wgt[l] = '0;
      end else if (neg_q[l]) begin
        wgt[l] = WeightW'(-$signed({1'b0, rnd[l]}));
      end else if (rnd[l] >= ((QuotW + 1)'(1) << (WeightW - 1))) begin
        wgt[l] = {1'b0, {(WeightW - 1){1'b1}}};
      end else begin
        wgt[l] = WeightW'(rnd[l]);
      end
    end
  end
  assign dbit = 1'b0;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (included_i) state_d = F_MUL;
          else if (last_point_i) state_d = F_PUSH;
        end
      end
      F_MUL: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(MulSteps)) state_d = F_NW;
      end
      F_NW: begin
        state_d = F_ABS;
      end
      F_ABS: begin
        state_d = degen_q ? F_PUSH : F_SAT;
      end
      F_SAT: begin
        state_d = F_DIV;
        cnt_d   = 5'(QuotW - 1);
      end
      F_DIV: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      index_q <= point_index_i;
      y_q     <= sample_value_i;
      incl_q  <= included_i;
      last_q  <= last_point_i;
      degen_q <= 1'b0;
      ax_q <= {cfg_i.v1x[CoordW-1], cfg_i.v1x} - {cfg_i.v0x[CoordW-1], cfg_i.v0x};
      ay_q <= {cfg_i.v1y[CoordW-1], cfg_i.v1y} - {cfg_i.v0y[CoordW-1], cfg_i.v0y};
      bx_q <= {cfg_i.v2x[CoordW-1], cfg_i.v2x} - {cfg_i.v0x[CoordW-1], cfg_i.v0x};
      by_q <= {cfg_i.v2y[CoordW-1], cfg_i.v2y} - {cfg_i.v0y[CoordW-1], cfg_i.v0y};
      px_q <= {point_x_i[CoordW-1], point_x_i} - {cfg_i.v0x[CoordW-1], cfg_i.v0x};
      py_q <= {point_y_i[CoordW-1], point_y_i} - {cfg_i.v0y[CoordW-1], cfg_i.v0y};
    end

    // product one step ahead of its accumulation
    if (state_q == F_MUL) begin
      prod_q <= prod_d;
      if (cnt_q != '0) begin
        unique case (ms_acc.dst)
          DST_D00: d00_q <= ms_acc.first ? DotW'(addend) : d00_q + DotW'(addend);
          DST_D01: d01_q <= ms_acc.first ? DotW'(addend) : d01_q + DotW'(addend);
          DST_D11: d11_q <= ms_acc.first ? DotW'(addend) : d11_q + DotW'(addend);
          DST_D20: d20_q <= ms_acc.first ? DotW'(addend) : d20_q + DotW'(addend);
          DST_D21: d21_q <= ms_acc.first ? DotW'(addend) : d21_q + DotW'(addend);
          DST_DEN: den_q <= ms_acc.first ? addend : den_q + addend;
          DST_NU:  nu_q  <= ms_acc.first ? addend : nu_q + addend;
          DST_NV:  nv_q  <= ms_acc.first ? addend : nv_q + addend;
          default: ;
        endcase
      end
    end

    if (state_q == F_NW) begin
      nw_q    <= NumW'(den_q) - NumW'(nu_q) - NumW'(nv_q);
      degen_q <= (den_q == '0) || ({8'b0, den_q} < {10'b0, cfg_i.thr});
    end

    for (int l = 0; l < 3; l++) begin
      if (state_q == F_ABS) begin
        neg_q[l] <= num[l][NumW-1];
        mag_q[l] <= BigW'(num[l][NumW-1] ? -num[l] : num[l]);
      end
      if (state_q == F_SAT) begin
        sat_q[l] <= ({SatShift'(1'b0), mag_q[l]} >= ({SatShift'(1'b0), den_q} << SatShift));
        rem_q[l] <= mag_q[l] >> SatShift;
        quo_q[l] <= '0;
      end
      if (state_q == F_DIV) begin
        if (trial[l] >= NumW'(den_q)) begin
          rem_q[l] <= BigW'(trial[l] - NumW'(den_q));
          quo_q[l] <= {quo_q[l][QuotW-2:0], 1'b1};
        end else begin
          rem_q[l] <= BigW'(trial[l]);
          quo_q[l] <= {quo_q[l][QuotW-2:0], dbit};
        end
      end
    end
  end

  always_comb begin
    rec_o.index = index_q;
    rec_o.w0    = wgt[0];
    rec_o.w1    = wgt[1];
    rec_o.w2    = wgt[2];
    rec_o.degen = degen_q && incl_q;
    rec_o.y     = y_q;
    rec_o.incl  = incl_q;
    rec_o.last  = last_q;
  end

endmodule

// ===== hdl/bwa_fifo.sv =====
module bwa_fifo
  import bwa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output rec_t rdata_o,
  output logic empty_o
);

  rec_t                  mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [FifoPtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW + 1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> !empty_o) else $error("queue lost a transaction");
`endif

endmodule

// ===== hdl/bwa_back.sv =====
module bwa_back
  import bwa_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rec_t                      rec_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      result_kind_o,
  output logic [IndexW-1:0]         echo_index_o,
  output logic signed [WeightW-1:0] weight_vertex0_o,
  output logic signed [WeightW-1:0] weight_vertex1_o,
  output logic signed [WeightW-1:0] weight_vertex2_o,
  output logic                      degenerate_o,
  output logic [StatIdW-1:0]        stat_id_o,
  output logic signed [StatW-1:0]   stat_value_o,
  output logic                      last_result_o
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned ProdW = 2 * WeightW;

  back_state_e state_q, state_d;
  logic [StatIdW-1:0] cnt_q, cnt_d;

  logic signed [StatW-1:0]   sums_q [NumSums];
  logic [CntW-1:0]           count_q;
  logic signed [WeightW-1:0] w_q [3];
  logic signed [ValueW-1:0]  y_q;
  logic                      last_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [WeightW-1:0] ma, mb;
  logic signed [StatW:0]     sum_ext;
  logic signed [StatW-1:0]   sum_sat, stat_sel;
  logic [StatIdW-1:0]        acc_idx;

  logic out_free, take_rec, load_stat;

  assign out_free  = !out_valid_o || !out_stall_i;
  assign take_rec  = (state_q == B_IDLE) && !empty_i && out_free;
  assign load_stat = (state_q == B_STAT) && out_free;
  assign pop_o     = take_rec;
  assign acc_idx   = cnt_q - 1'b1;

  // one product per cycle: w*y, then the pairs, then y*y
  always_comb begin
    ma = w_q[0];
    mb = WeightW'(y_q);
    case (cnt_q)
      4'd0:    begin ma = w_q[0]; mb = WeightW'(y_q); end
      4'd1:    begin ma = w_q[1]; mb = WeightW'(y_q); end
      4'd2:    begin ma = w_q[2]; mb = WeightW'(y_q); end
      4'd3:    begin ma = w_q[0]; mb = w_q[0]; end
      4'd4:    begin ma = w_q[0]; mb = w_q[1]; end
      4'd5:    begin ma = w_q[0]; mb = w_q[2]; end
      4'd6:    begin ma = w_q[1]; mb = w_q[1]; end
      4'd7:    begin ma = w_q[1]; mb = w_q[2]; end
      4'd8:    begin ma = w_q[2]; mb = w_q[2]; end
      default: begin ma = WeightW'(y_q); mb = WeightW'(y_q); end
    endcase
  end

  assign sum_ext = (StatW + 1)'(sums_q[acc_idx]) + (StatW + 1)'(prod_q);
  always_comb begin
    if (sum_ext[StatW] != sum_ext[StatW-1]) begin
      sum_sat = sum_ext[StatW] ? {1'b1, {(StatW - 1){1'b0}}} : {1'b0, {(StatW - 1){1'b1}}};
    end else begin
      sum_sat = sum_ext[StatW-1:0];
    end
  end

  assign stat_sel = (cnt_q == StatCount) ? StatW'(count_q) : sums_q[cnt_q];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      B_IDLE: begin
        cnt_d = '0;
        if (take_rec) begin
          if (rec_i.incl && !rec_i.degen) state_d = B_ACC;
          else if (rec_i.last) state_d = B_STAT;
        end
      end
      B_ACC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StatIdW'(NumSums)) begin
          cnt_d   = '0;
          state_d = last_q ? B_STAT : B_IDLE;
        end
      end
      B_STAT: begin
        if (load_stat) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == StatCount) state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      count_q     <= '0;
      for (int i = 0; i < NumSums; i++) sums_q[i] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      // a stalled transaction stays, a new one loads only when the output is free
      out_valid_o <= !out_free || (take_rec && rec_i.incl) || load_stat;
      if (state_q == B_ACC) begin
        if (cnt_q != '0) sums_q[acc_idx] <= sum_sat;
        if (cnt_q == StatIdW'(NumSums) && count_q != CntW'(MAX_POINTS)) begin
          count_q <= count_q + 1'b1;
        end
      end
      // each statistic is cleared as it goes out
      if (load_stat) begin
        if (cnt_q == StatCount) count_q <= '0;
        else sums_q[cnt_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_rec) begin
      w_q[0] <= rec_i.w0;
      w_q[1] <= rec_i.w1;
      w_q[2] <= rec_i.w2;
      y_q    <= rec_i.y;
      last_q <= rec_i.last;
    end
    if (state_q == B_ACC && cnt_q != StatIdW'(NumSums)) prod_q <= ma * mb;
    if (take_rec && rec_i.incl) begin
      result_kind_o    <= KindWeight;
      echo_index_o     <= rec_i.index;
      weight_vertex0_o <= rec_i.w0;
      weight_vertex1_o <= rec_i.w1;
      weight_vertex2_o <= rec_i.w2;
      degenerate_o     <= rec_i.degen;
      stat_id_o        <= '0;
      stat_value_o     <= '0;
      last_result_o    <= !rec_i.last;
    end
    if (load_stat) begin
      result_kind_o    <= KindStat;
      echo_index_o     <= '0;
      weight_vertex0_o <= '0;
      weight_vertex1_o <= '0;
      weight_vertex2_o <= '0;
      degenerate_o     <= 1'b0;
      stat_id_o        <= cnt_q;
      stat_value_o     <= stat_sel;
      last_result_o    <= (cnt_q == StatCount);
    end
  end

endmodule

// ===== hdl/barycentric_weight_accumulator.sv =====
// the front holds one point at a time: an included point stalls the input until it is pushed,
// held up by the 16 products on the shared 28x28 multiplier and the 24-step restoring
//   divider; a skipped point that is not last is taken without a stall
// a last point adds 11 statistic transactions after its own weight transaction, if any
// reset: vertices to 0, threshold to 1, all sums and the count cleared at once
module barycentric_weight_accumulator
  import bwa_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // apb-style configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CfgAddrW-1:0]       paddr,
  input  logic [CfgDataW-1:0]       pwdata,
  output logic [CfgDataW-1:0]       prdata,
  output logic                      pready,
  // point stream
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [IndexW-1:0]         point_index_i,
  input  logic signed [CoordW-1:0]  point_x_i,
  input  logic signed [CoordW-1:0]  point_y_i,
  input  logic signed [ValueW-1:0]  sample_value_i,
  input  logic                      included_i,
  input  logic                      last_point_i,
  // result stream
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      result_kind_o,
  output logic [IndexW-1:0]         echo_index_o,
  output logic signed [WeightW-1:0] weight_vertex0_o,
  output logic signed [WeightW-1:0] weight_vertex1_o,
  output logic signed [WeightW-1:0] weight_vertex2_o,
  output logic                      degenerate_o,
  output logic [StatIdW-1:0]        stat_id_o,
  output logic signed [StatW-1:0]   stat_value_o,
  output logic                      last_result_o
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  // registers sit 8 bytes apart since the threshold needs more than 32 bits
  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{v0x: '0, v0y: '0, v1x: '0, v1y: '0, v2x: '0, v2y: '0, thr: ThrW'(1)};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegV0X:  cfg_q.v0x <= pwdata[CoordW-1:0];
        RegV0Y:  cfg_q.v0y <= pwdata[CoordW-1:0];
        RegV1X:  cfg_q.v1x <= pwdata[CoordW-1:0];
        RegV1Y:  cfg_q.v1y <= pwdata[CoordW-1:0];
        RegV2X:  cfg_q.v2x <= pwdata[CoordW-1:0];
        RegV2Y:  cfg_q.v2y <= pwdata[CoordW-1:0];
        RegThr:  cfg_q.thr <= pwdata[ThrW-1:0];
        default: ;  // addresses past the threshold are ignored
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      RegV0X:  prdata = CfgDataW'(cfg_q.v0x);
      RegV0Y:  prdata = CfgDataW'(cfg_q.v0y);
      RegV1X:  prdata = CfgDataW'(cfg_q.v1x);
      RegV1Y:  prdata = CfgDataW'(cfg_q.v1y);
      RegV2X:  prdata = CfgDataW'(cfg_q.v2x);
      RegV2Y:  prdata = CfgDataW'(cfg_q.v2y);
      RegThr:  prdata = CfgDataW'(cfg_q.thr);
      default: prdata = '0;
    endcase
  end

  rec_t front_rec, back_rec;
  logic push, full, pop, empty;

  // front: differences, dot products, determinant, numerators, division
  bwa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_index_i  (point_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .sample_value_i (sample_value_i),
    .included_i     (included_i),
    .last_point_i   (last_point_i),
    .push_o         (push),
    .rec_o          (front_rec),
    .full_i         (full)
  );

  // short queue so the two halves stall on their own
  bwa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (back_rec),
    .empty_o (empty)
  );

  // back: weight transaction, saturating sums, statistic dump
  bwa_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_i            (back_rec),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .echo_index_o     (echo_index_o),
    .weight_vertex0_o (weight_vertex0_o),
    .weight_vertex1_o (weight_vertex1_o),
    .weight_vertex2_o (weight_vertex2_o),
    .degenerate_o     (degenerate_o),
    .stat_id_o        (stat_id_o),
    .stat_value_o     (stat_value_o),
    .last_result_o    (last_result_o)
  );

`ifndef SYNTHESIS
  a_count_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindStat && stat_id_o == StatCount |-> last_result_o)
    else $error("count statistic not marked last");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      weight_vertex0_o == '0 && weight_vertex1_o == '0 && weight_vertex2_o == '0)
    else $error("degenerate transaction carries weights");
  a_stat_no_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindStat |-> echo_index_o == '0 && !degenerate_o)
    else $error("statistic transaction carries point fields");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import bwa_pkg::*;

  // one point transaction as offered on the input channel
  typedef struct {
    logic [IndexW-1:0]        index;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [ValueW-1:0] y;
    logic                     incl;
    logic                     last;
  } point_t;

  // one result transaction as seen on the output channel
  typedef struct {
    logic                      kind;
    logic [IndexW-1:0]         index;
    logic signed [WeightW-1:0] w0;
    logic signed [WeightW-1:0] w1;
    logic signed [WeightW-1:0] w2;
    logic                      degen;
    logic [StatIdW-1:0]        id;
    logic signed [StatW-1:0]   value;
    logic                      last;
  } result_t;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned DrainCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [IndexW-1:0] point_index_i = '0;
  logic signed [CoordW-1:0] point_x_i = '0, point_y_i = '0;
  logic signed [ValueW-1:0] sample_value_i = '0;
  logic included_i = 1'b0, last_point_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic result_kind_o;
  logic [IndexW-1:0] echo_index_o;
  logic signed [WeightW-1:0] weight_vertex0_o, weight_vertex1_o, weight_vertex2_o;
  logic degenerate_o;
  logic [StatIdW-1:0] stat_id_o;
  logic signed [StatW-1:0] stat_value_o;
  logic last_result_o;

  barycentric_weight_accumulator u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state: triangle, threshold and the running sums
  logic signed [CoordW-1:0] tri_x[3], tri_y[3];
  logic [ThrW-1:0] degen_limit;
  logic signed [StatW-1:0] acc_wy[3];
  logic signed [StatW-1:0] acc_ww[6];
  logic signed [StatW-1:0] acc_yy;
  int unsigned acc_count;

  point_t  pending_points[$];
  result_t expected_results[$];
  int errors = 0;
  int weights_seen = 0, stats_seen = 0, degen_seen = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;

  function automatic logic signed [StatW-1:0] add_sat(logic signed [StatW-1:0] a,
                                                      logic signed [127:0] b);
    logic signed [127:0] s;
    s = 128'(a) + b;
    if (s > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // num * 2^16 / den, half away from zero, clamped to the weight range
  function automatic logic signed [WeightW-1:0] weight_q16(logic signed [127:0] num,
                                                           logic signed [127:0] den);
    logic [127:0] mag, q;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag << 17) / den + 1) >> 1;
    if (neg) return (q >= (1 << 23)) ? -24'sd8388608 : -$signed(q[23:0]);
    return (q > 128'd8388607) ? 24'sd8388607 : q[23:0];
  endfunction

  task automatic clear_sums();
    for (int i = 0; i < 3; i++) acc_wy[i] = '0;
    for (int i = 0; i < 6; i++) acc_ww[i] = '0;
    acc_yy = '0;
    acc_count = 0;
  endtask

  task automatic predict_point(point_t p);
    logic signed [127:0] ax, ay, bx, by, qx, qy, d00, d01, d11, d20, d21, den, nu, nv;
    logic signed [WeightW-1:0] w[3];
    logic degen;
    result_t r;
    int k;
    if (p.incl) begin
      ax = tri_x[1] - tri_x[0]; ay = tri_y[1] - tri_y[0];
      bx = tri_x[2] - tri_x[0]; by = tri_y[2] - tri_y[0];
      qx = p.px - tri_x[0];     qy = p.py - tri_y[0];
      d00 = ax * ax + ay * ay;
      d01 = ax * bx + ay * by;
      d11 = bx * bx + by * by;
      den = d00 * d11 - d01 * d01;
      degen = den <= 0 || den < $signed({74'd0, degen_limit});
      w = '{default: '0};
      if (!degen) begin
        d20 = qx * ax + qy * ay;
        d21 = qx * bx + qy * by;
        nu = d11 * d20 - d01 * d21;
        nv = d00 * d21 - d01 * d20;
        w[0] = weight_q16(den - nu - nv, den);
        w[1] = weight_q16(nu, den);
        w[2] = weight_q16(nv, den);
        k = 0;
        for (int i = 0; i < 3; i++) begin
          acc_wy[i] = add_sat(acc_wy[i], 128'(w[i]) * 128'(p.y));
          for (int j = i; j < 3; j++) begin
            acc_ww[k] = add_sat(acc_ww[k], 128'(w[i]) * 128'(w[j]));
            k++;
          end
        end
        acc_yy = add_sat(acc_yy, 128'(p.y) * 128'(p.y));
        if (acc_count < MaxPoints) acc_count++;
      end
      r = '{kind: KindWeight, index: p.index, w0: w[0], w1: w[1], w2: w[2],
            degen: degen, id: '0, value: '0, last: !p.last};
      expected_results = {expected_results, r};
    end
    if (p.last) begin
      for (int i = 0; i < 11; i++) begin
        r = '{kind: KindStat, index: '0, w0: '0, w1: '0, w2: '0, degen: 1'b0,
              id: i[StatIdW-1:0], value: '0, last: (i == StatCount)};
        if (i < 3) r.value = acc_wy[i];
        else if (i < 9) r.value = acc_ww[i - 3];
        else if (i == 9) r.value = acc_yy;
        else r.value = acc_count;
        expected_results = {expected_results, r};
      end
      clear_sums();
    end
  endtask

  // driver: offer queued points, change inputs at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          in_valid_i <= 1'b1;
          point_index_i <= p.index; point_x_i <= p.px; point_y_i <= p.py;
          sample_value_i <= p.y; included_i <= p.incl; last_point_i <= p.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_point('{index: point_index_i, px: point_x_i, py: point_y_i,
                      y: sample_value_i, incl: included_i, last: last_point_i});
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction kind=%0d", $time, result_kind_o);
        errors++;
      end else begin
        result_t e, a;
        e = expected_results.pop_front();
        a = '{kind: result_kind_o, index: echo_index_o, w0: weight_vertex0_o,
              w1: weight_vertex1_o, w2: weight_vertex2_o, degen: degenerate_o,
              id: stat_id_o, value: stat_value_o, last: last_result_o};
        if (a != e) begin
          $display("%0t: expected kind=%0d idx=%0d w=%0d/%0d/%0d dg=%0d id=%0d v=%0d l=%0d",
                   $time, e.kind, e.index, e.w0, e.w1, e.w2, e.degen, e.id, e.value, e.last);
          $display("%0t: actual   kind=%0d idx=%0d w=%0d/%0d/%0d dg=%0d id=%0d v=%0d l=%0d",
                   $time, a.kind, a.index, a.w0, a.w1, a.w2, a.degen, a.id, a.value, a.last);
          errors++;
        end
        if (a.kind == KindWeight) weights_seen++; else stats_seen++;
        if (a.kind == KindWeight && a.degen) degen_seen++;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= CfgAddrW'(idx) << 3; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < RegThr) begin
      if (idx[0]) tri_y[idx >> 1] = value[CoordW-1:0];
      else tri_x[idx >> 1] = value[CoordW-1:0];
    end else begin
      degen_limit = value[ThrW-1:0];
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2,
                              logic [ThrW-1:0] thr);
    write_reg(RegV0X, CfgDataW'(x0)); write_reg(RegV0Y, CfgDataW'(y0));
    write_reg(RegV1X, CfgDataW'(x1)); write_reg(RegV1Y, CfgDataW'(y1));
    write_reg(RegV2X, CfgDataW'(x2)); write_reg(RegV2Y, CfgDataW'(y2));
    write_reg(RegThr, CfgDataW'(thr));
  endtask

  // wait for every expectation, then give in-flight skipped points time to retire
  task automatic wait_idle();
    while (pending_points.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_point(int idx, int x, int y, int v, bit incl, bit last);
    point_t p;
    p = '{index: IndexW'(idx), px: CoordW'(x), py: CoordW'(y), y: ValueW'(v),
          incl: incl, last: last};
    pending_points = {pending_points, p};
  endtask

  // mostly sets of included points with a last marker, some skipped noise
  task automatic queue_random_set(int n, bit near_tri);
    for (int i = 0; i < n; i++) begin
      int x, y;
      if (near_tri) begin
        x = tri_x[$urandom_range(2)] + $signed($urandom_range(400)) - 200;
        y = tri_y[$urandom_range(2)] + $signed($urandom_range(400)) - 200;
        x = x > 2047 ? 2047 : (x < -2048 ? -2048 : x);
        y = y > 2047 ? 2047 : (y < -2048 ? -2048 : y);
      end else begin
        x = $signed(12'($urandom)); y = $signed(12'($urandom));
      end
      queue_point($urandom_range(4095), x, y, $signed(16'($urandom)),
                  $urandom_range(9) != 0, i == n - 1);
    end
  endtask

  initial begin
    tri_x = '{default: '0}; tri_y = '{default: '0};
    degen_limit = 1;
    clear_sums();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset triangle is a point: degenerate, count stays zero
    queue_point(0, 5, -5, 100, 1, 0);
    queue_point(4095, 0, 0, 0, 0, 1);
    wait_idle();

    // unit-ish triangle, vertices and interior, skipped point, extremes
    set_triangle(0, 0, 64, 0, 0, 64, 1);
    queue_point(1, 0, 0, 32767, 1, 0);
    queue_point(2, 64, 0, -32768, 1, 0);
    queue_point(3, 0, 64, 1, 1, 0);
    queue_point(4, 21, 21, -1, 1, 0);
    queue_point(5, 32, 32, 5, 0, 0);
    queue_point(6, 2047, 2047, 32767, 1, 0);
    queue_point(7, -2048, -2048, -32768, 1, 0);
    queue_point(8, 1, 1, 0, 1, 1);
    wait_idle();

    // largest triangle, zero threshold, ties in rounding
    set_triangle(-2048, -2048, 2047, -2048, -2048, 2047, 0);
    queue_point(9, 2047, 2047, -32768, 1, 0);
    queue_point(10, -2048, 2047, 32767, 1, 0);
    queue_point(11, 0, 0, 7, 1, 1);
    wait_idle();

    // thin triangle and threshold at the top: degenerate through threshold
    set_triangle(0, 0, 2047, 1, 2046, 1, 54'h3F_FFFF_FFFF_FFFF);
    queue_point(12, 100, 0, 3, 1, 0);
    queue_point(13, 0, 0, 3, 1, 1);
    wait_idle();

    // collinear vertices with zero threshold
    set_triangle(-10, -10, 10, 10, 20, 20, 0);
    queue_point(14, 3, 4, 9, 1, 1);
    wait_idle();

    // thin but valid triangle gives huge weights that saturate
    set_triangle(0, 0, 2047, 1, 2046, 1, 1);
    queue_point(15, -2048, 2047, 32767, 1, 0);
    queue_point(16, 2047, -2048, -32768, 1, 1);
    wait_idle();

    // random phases with several triangles and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 4)
        set_triangle(2047, 2047, -2048, 2047, 2047, -2048, ThrW'($urandom_range(3)));
      else
        set_triangle($signed(12'($urandom)), $signed(12'($urandom)),
                     $signed(12'($urandom)), $signed(12'($urandom)),
                     $signed(12'($urandom)), $signed(12'($urandom)),
                     ($urandom_range(7) == 0) ? ThrW'({$urandom, $urandom})
                                              : ThrW'($urandom_range(100)));
      for (int s = 0; s < 7; s++) queue_random_set($urandom_range(3, 14), $urandom_range(1));
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_idle();
    end

    $display("covered %0d weight and %0d statistic transactions, %0d degenerate",
             weights_seen, stats_seen, degen_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== barycentric_weight_accumulator.f =====
hdl/bwa_pkg.sv
hdl/bwa_front.sv
hdl/bwa_fifo.sv
hdl/bwa_back.sv
hdl/barycentric_weight_accumulator.sv
tb/testbench.sv
